// ----- sv/bfp_pkg.sv -----
// Shared constants, types and helpers for the beacon frame parser.
package bfp_pkg;

  localparam int BUFFER_BYTES = 16;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W        = $clog2(BUFFER_BYTES);
  // Bytes a decoder ever looks at: beacon id plus x, y, z.
  localparam int FRAME_BYTES  = 13;

  localparam int MID_DEPTH  = 2;
  localparam int MID_PTR_W  = $clog2(MID_DEPTH);
  localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_HEADER   = 3'd0;
  localparam logic [2:0] REG_ID_BPOS  = 3'd1;
  localparam logic [2:0] REG_ID_BDIST = 3'd2;
  localparam logic [2:0] REG_ID_VPOS  = 3'd3;
  localparam logic [2:0] REG_MAX_LEN  = 3'd4;
  localparam logic [2:0] REG_MAX_RNG  = 3'd5;

  localparam logic [7:0]  RST_HEADER   = 8'd1;
  localparam logic [7:0]  RST_ID_BPOS  = 8'd2;
  localparam logic [7:0]  RST_ID_BDIST = 8'd3;
  localparam logic [7:0]  RST_ID_VPOS  = 8'd4;
  localparam logic [7:0]  RST_MAX_LEN  = 8'd13;
  localparam logic [31:0] RST_MAX_RNG  = 32'd200000;

  typedef enum logic [1:0] {
    KIND_BPOS  = 2'd0,
    KIND_BDIST = 2'd1,
    KIND_VPOS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ID     = 2'd1,
    PH_LEN    = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  header;
    logic [7:0]  id_bpos;
    logic [7:0]  id_bdist;
    logic [7:0]  id_vpos;
    logic [7:0]  max_len;
    logic [31:0] max_range;
  } cfg_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    kind_t        kind;
    frame_bytes_t bytes;
  } frame_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         station_id;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [32:0]        pos_z;
    logic [31:0]        range;
  } result_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } kind_hit_t;

  // Id lookup; on equal ids beacon position wins, then beacon distance.
  function automatic kind_hit_t kind_of(logic [7:0] id, cfg_t c);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = KIND_BPOS;
    if (id == c.id_bpos) r.kind = KIND_BPOS;
    else if (id == c.id_bdist) r.kind = KIND_BDIST;
    else if (id == c.id_vpos) r.kind = KIND_VPOS;
    else r.hit = 1'b0;
    return r;
  endfunction

  // Little-endian 32-bit word at a fixed byte offset.
  function automatic logic [31:0] le32(frame_bytes_t b, int unsigned at);
    return {b[at+3], b[at+2], b[at+1], b[at]};
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ----- sv/bfp_front.sv -----
// Byte parser: header/id/length/payload state machine, payload store, checksum.
module bfp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfp_pkg::cfg_t         cfg,
  input  logic                  in_push,
  input  logic [7:0]            in_rx_byte,
  input  logic                  fr_full,
  output logic                  fr_push,
  output bfp_pkg::frame_t       fr_din
);

  bfp_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]               frame_id_r, frame_id_nxt;
  logic [7:0]               frame_len_r, frame_len_nxt;
  logic [bfp_pkg::CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]               xor_r, xor_nxt;
  logic [7:0]               store_r [bfp_pkg::BUFFER_BYTES];

  logic                     acc;
  logic [bfp_pkg::IDX_W-1:0] wr_idx;
  logic [bfp_pkg::CNT_W-1:0] cnt_inc;
  logic [7:0]               data_xor;
  logic                     last_byte;
  bfp_pkg::kind_hit_t       rx_kind, frame_kind;

  assign acc        = in_push && !fr_full;
  assign wr_idx     = byte_count_r[bfp_pkg::IDX_W-1:0];
  assign cnt_inc    = byte_count_r + 1'b1;
  assign data_xor   = xor_r ^ in_rx_byte;
  // Ends on the stated length or a full store; a length of zero never matches.
  assign last_byte  = (8'(cnt_inc) == frame_len_r) ||
                      (cnt_inc >= bfp_pkg::CNT_W'(bfp_pkg::BUFFER_BYTES));
  assign rx_kind    = bfp_pkg::kind_of(in_rx_byte, cfg);
  assign frame_kind = bfp_pkg::kind_of(frame_id_r, cfg);

  // Snapshot includes the byte being written this cycle.
  always_comb begin
    fr_din.kind = frame_kind.kind;
    for (int k = 0; k < bfp_pkg::FRAME_BYTES; k++) begin
      fr_din.bytes[k] = (wr_idx == bfp_pkg::IDX_W'(k)) ? in_rx_byte : store_r[k];
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    frame_id_nxt   = frame_id_r;
    frame_len_nxt  = frame_len_r;
    byte_count_nxt = byte_count_r;
    xor_nxt        = xor_r;
    fr_push        = 1'b0;
    if (acc) begin
      case (phase_r)
        bfp_pkg::PH_HEADER: begin
          if (in_rx_byte == cfg.header) begin
            phase_nxt      = bfp_pkg::PH_ID;
            byte_count_nxt = '0;
          end
        end
        bfp_pkg::PH_ID: begin
          frame_id_nxt = in_rx_byte;
          phase_nxt    = rx_kind.hit ? bfp_pkg::PH_LEN : bfp_pkg::PH_HEADER;
        end
        bfp_pkg::PH_LEN: begin
          frame_len_nxt = in_rx_byte;
          if (in_rx_byte > cfg.max_len) begin
            phase_nxt = bfp_pkg::PH_HEADER;
          end else begin
            xor_nxt   = frame_id_r ^ in_rx_byte;
            phase_nxt = bfp_pkg::PH_DATA;
          end
        end
        bfp_pkg::PH_DATA: begin
          byte_count_nxt = cnt_inc;
          xor_nxt        = data_xor;
          if (last_byte) begin
            phase_nxt = bfp_pkg::PH_HEADER;
            fr_push   = (data_xor == 8'd0) && frame_kind.hit;
          end
        end
        default: phase_nxt = bfp_pkg::PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bfp_pkg::PH_HEADER;
      frame_id_r   <= '0;
      frame_len_r  <= '0;
      byte_count_r <= '0;
      xor_r        <= '0;
    end else begin
      phase_r      <= phase_nxt;
      frame_id_r   <= frame_id_nxt;
      frame_len_r  <= frame_len_nxt;
      byte_count_r <= byte_count_nxt;
      xor_r        <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && phase_r == bfp_pkg::PH_DATA) begin
      store_r[wr_idx] <= in_rx_byte;
    end
  end

  a_data_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bfp_pkg::PH_DATA) |->
      (byte_count_r < bfp_pkg::CNT_W'(bfp_pkg::BUFFER_BYTES)))
    else $error("payload count past store size");

  a_frame_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    fr_push |=> (phase_r == bfp_pkg::PH_HEADER))
    else $error("parser did not return to header wait after a frame");

  a_push_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    fr_push |-> (phase_r == bfp_pkg::PH_DATA && acc))
    else $error("frame pushed outside payload phase");

endmodule

// ----- sv/bfp_frame_queue.sv -----
// Short queue of checked frames between the parser and the decoder.
module bfp_frame_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bfp_pkg::frame_t  din,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bfp_pkg::frame_t  dout
);

  bfp_pkg::frame_t               mem_r [bfp_pkg::MID_DEPTH];
  logic [bfp_pkg::MID_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bfp_pkg::MID_CNT_W-1:0] count_r;

  assign full  = (count_r == bfp_pkg::MID_CNT_W'(bfp_pkg::MID_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ----- sv/bfp_back.sv -----
// Frame decoder: field extraction, magnitude squares, range test.
module bfp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [31:0]                   max_range,
  input  logic                          fr_empty,
  input  bfp_pkg::frame_t               fr_dout,
  output logic                          fr_pop,
  input  logic [bfp_pkg::OUT_CNT_W-1:0] res_count,
  output logic                          res_push,
  output bfp_pkg::result_t              res_din
);

  typedef struct packed {
    bfp_pkg::kind_t kind;
    logic [7:0]     bid;
    logic [31:0]    x;
    logic [31:0]    y;
    logic [31:0]    z;
    logic [31:0]    d;
    logic [31:0]    mx;
    logic [31:0]    my;
    logic [31:0]    mz;
  } s1_t;

  typedef struct packed {
    bfp_pkg::kind_t kind;
    logic [7:0]     bid;
    logic [31:0]    x;
    logic [31:0]    y;
    logic [31:0]    z;
    logic [31:0]    d;
    logic [63:0]    sx;
    logic [63:0]    sy;
    logic [63:0]    sz;
    logic [63:0]    lim;
  } s2_t;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r;
  logic v1_r, v2_r;

  logic [bfp_pkg::OUT_CNT_W:0] committed;
  logic [31:0] bx, by, bz, vx, vy, vz;
  logic [65:0] sq_sum;
  logic        pass;

  // Credit check: queued results plus frames in flight must fit the result queue.
  assign committed = {1'b0, res_count} + (bfp_pkg::OUT_CNT_W+1)'(v1_r)
                   + (bfp_pkg::OUT_CNT_W+1)'(v2_r);
  assign fr_pop = !fr_empty &&
                  (committed < (bfp_pkg::OUT_CNT_W+1)'(bfp_pkg::OUT_DEPTH));

  assign bx = bfp_pkg::le32(fr_dout.bytes, 1);
  assign by = bfp_pkg::le32(fr_dout.bytes, 5);
  assign bz = bfp_pkg::le32(fr_dout.bytes, 9);
  assign vx = bfp_pkg::le32(fr_dout.bytes, 0);
  assign vy = bfp_pkg::le32(fr_dout.bytes, 4);
  assign vz = bfp_pkg::le32(fr_dout.bytes, 8);

  always_comb begin
    s1_nxt.kind = fr_dout.kind;
    s1_nxt.bid  = fr_dout.bytes[0];
    s1_nxt.d    = bx;
    case (fr_dout.kind)
      bfp_pkg::KIND_BPOS: begin
        s1_nxt.x = bx;
        s1_nxt.y = by;
        s1_nxt.z = bz;
      end
      bfp_pkg::KIND_VPOS: begin
        s1_nxt.x = vx;
        s1_nxt.y = vy;
        s1_nxt.z = vz;
      end
      default: begin
        s1_nxt.x = '0;
        s1_nxt.y = '0;
        s1_nxt.z = '0;
      end
    endcase
    s1_nxt.mx = bfp_pkg::mag32(s1_nxt.x);
    s1_nxt.my = bfp_pkg::mag32(s1_nxt.y);
    s1_nxt.mz = bfp_pkg::mag32(s1_nxt.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= fr_pop;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_pop) s1_r <= s1_nxt;
    if (v1_r) begin
      s2_r.kind <= s1_r.kind;
      s2_r.bid  <= s1_r.bid;
      s2_r.x    <= s1_r.x;
      s2_r.y    <= s1_r.y;
      s2_r.z    <= s1_r.z;
      s2_r.d    <= s1_r.d;
      s2_r.sx   <= 64'(s1_r.mx) * 64'(s1_r.mx);
      s2_r.sy   <= 64'(s1_r.my) * 64'(s1_r.my);
      s2_r.sz   <= 64'(s1_r.mz) * 64'(s1_r.mz);
      s2_r.lim  <= 64'(max_range) * 64'(max_range);
    end
  end

  assign sq_sum = 66'(s2_r.sx) + 66'(s2_r.sy) + 66'(s2_r.sz);
  assign pass   = (s2_r.kind == bfp_pkg::KIND_BDIST) ? (s2_r.d <= max_range)
                                                     : (sq_sum <= 66'(s2_r.lim));
  assign res_push = v2_r && pass;

  always_comb begin
    res_din.kind       = s2_r.kind;
    res_din.station_id = (s2_r.kind == bfp_pkg::KIND_VPOS) ? 8'd0 : s2_r.bid;
    res_din.pos_x      = s2_r.x;
    res_din.pos_y      = s2_r.y;
    res_din.pos_z      = 33'd0 - {s2_r.z[31], s2_r.z};
    res_din.range      = (s2_r.kind == bfp_pkg::KIND_BDIST) ? s2_r.d : 32'd0;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_count < bfp_pkg::OUT_CNT_W'(bfp_pkg::OUT_DEPTH)))
    else $error("result pushed into a full result queue");

  a_pipe_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fr_pop |=> ##1 v2_r)
    else $error("popped frame lost in decode pipeline");

endmodule

// ----- sv/bfp_result_queue.sv -----
// Output queue of decoded results.
module bfp_result_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  bfp_pkg::result_t              din,
  output logic [bfp_pkg::OUT_CNT_W-1:0] count,
  input  logic                          pop,
  output logic                          empty,
  output bfp_pkg::result_t              dout
);

  bfp_pkg::result_t              mem_r [bfp_pkg::OUT_DEPTH];
  logic [bfp_pkg::OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bfp_pkg::OUT_CNT_W-1:0] count_r;
  logic                          do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign do_pop = pop && !empty;
  assign dout   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ----- sv/beacon_frame_parser_core.sv -----
// Top level of the beacon frame parser: config registers and the front/back split.
//
// Usage:
//  - Input side is a queue: drive in_rx_byte with in_push; a byte is taken on a
//    clock edge with in_push high and in_full low. One byte per cycle, no gaps
//    needed. in_full only rises when two checked frames wait for the decoder.
//  - Result side is a queue: while out_empty is low the oldest result sits on
//    the out_* ports; out_pop high on a clock edge removes it. Four results
//    are held, so the receiver may stall freely; when it does, frames back up
//    into the two-deep frame queue and then in_full stops the byte stream.
//  - Only good frames (valid id and length, zero XOR checksum, magnitude in
//    range) make a result. A frame passes the frame queue, the extract/abs
//    stage and the square stage, then the range compare into the result queue.
//  - While in_full is low the parser runs at one byte per cycle; decode is
//    pipelined; a new frame can enter the decoder each cycle with result credit.
//  - Configuration: cfg_we writes register cfg_idx (0 header byte, 1..3 ids,
//    4 max length, 5 max range) from cfg_wdata; other indexes are ignored.
//    Write only while no frame is in progress or being decoded.
//  - rst_n (synchronous, active low) restores the default registers, puts the
//    parser in header wait and empties both queues.
module beacon_frame_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_msg_kind,
  output logic [7:0]         out_station_id,
  output logic signed [31:0] out_pos_x_mm,
  output logic signed [31:0] out_pos_y_mm,
  output logic signed [32:0] out_pos_z_mm,
  output logic [31:0]        out_range_mm
);

  bfp_pkg::cfg_t    cfg_r;

  // Front to back
  logic             fr_push, fr_full, fr_pop, fr_empty;
  bfp_pkg::frame_t  fr_din, fr_dout;

  // Back to result queue
  logic                          res_push;
  bfp_pkg::result_t              res_din, res_dout;
  logic [bfp_pkg::OUT_CNT_W-1:0] res_count;

  // Config registers; narrow ones take the low byte of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header    <= bfp_pkg::RST_HEADER;
      cfg_r.id_bpos   <= bfp_pkg::RST_ID_BPOS;
      cfg_r.id_bdist  <= bfp_pkg::RST_ID_BDIST;
      cfg_r.id_vpos   <= bfp_pkg::RST_ID_VPOS;
      cfg_r.max_len   <= bfp_pkg::RST_MAX_LEN;
      cfg_r.max_range <= bfp_pkg::RST_MAX_RNG;
    end else if (cfg_we) begin
      case (cfg_idx)
        bfp_pkg::REG_HEADER:   cfg_r.header    <= cfg_wdata[7:0];
        bfp_pkg::REG_ID_BPOS:  cfg_r.id_bpos   <= cfg_wdata[7:0];
        bfp_pkg::REG_ID_BDIST: cfg_r.id_bdist  <= cfg_wdata[7:0];
        bfp_pkg::REG_ID_VPOS:  cfg_r.id_vpos   <= cfg_wdata[7:0];
        bfp_pkg::REG_MAX_LEN:  cfg_r.max_len   <= cfg_wdata[7:0];
        bfp_pkg::REG_MAX_RNG:  cfg_r.max_range <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = fr_full;

  bfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .fr_full    (fr_full),
    .fr_push    (fr_push),
    .fr_din     (fr_din)
  );

  bfp_frame_queue u_frame_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .din   (fr_din),
    .full  (fr_full),
    .pop   (fr_pop),
    .empty (fr_empty),
    .dout  (fr_dout)
  );

  bfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_range (cfg_r.max_range),
    .fr_empty  (fr_empty),
    .fr_dout   (fr_dout),
    .fr_pop    (fr_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_din   (res_din)
  );

  bfp_result_queue u_result_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .count (res_count),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_dout)
  );

  assign out_msg_kind   = res_dout.kind;
  assign out_station_id = res_dout.station_id;
  assign out_pos_x_mm   = res_dout.pos_x;
  assign out_pos_y_mm   = res_dout.pos_y;
  assign out_pos_z_mm   = res_dout.pos_z;
  assign out_range_mm   = res_dout.range;

endmodule

// ----- dv/tb_beacon_frame_parser_core.sv -----
// Self-checking testbench for beacon_frame_parser_core: byte stimulus, frame predictor, scoreboard.
module tb_beacon_frame_parser_core;
  import bfp_pkg::*;

  localparam int DRAIN_CYCLES     = 16;    // decode pipeline plus queues, items with no result
  localparam int TAIL_CYCLES      = 32;
  localparam int STALL_LIMIT      = 3000;  // cycles with no request moving on either side
  localparam int SECTION_BYTES    = 270;

  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [7:0] LEN_FILL  = 8'd0;   // run until the store is full
  localparam logic [7:0] LEN_BPOS  = 8'd13;
  localparam logic [7:0] LEN_BDIST = 8'd5;
  localparam logic [7:0] LEN_VPOS  = 8'd12;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = REG_HEADER;
  logic [31:0] cfg_wdata  = 32'd0;
  logic        in_push    = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_empty;
  logic        out_pop    = 1'b0;
  logic [1:0]         out_msg_kind;
  logic [7:0]         out_station_id;
  logic signed [31:0] out_pos_x_mm;
  logic signed [31:0] out_pos_y_mm;
  logic signed [32:0] out_pos_z_mm;
  logic [31:0]        out_range_mm;

  beacon_frame_parser_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_msg_kind   (out_msg_kind),
    .out_station_id (out_station_id),
    .out_pos_x_mm   (out_pos_x_mm),
    .out_pos_y_mm   (out_pos_y_mm),
    .out_pos_z_mm   (out_pos_z_mm),
    .out_range_mm   (out_range_mm)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle rates in percent, per side; changed between traffic phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int error_count    = 0;
  int bytes_sent     = 0;
  int stall_cycles   = 0;

  // Shadow of the register file and of the parser state.
  cfg_t       cur_cfg;
  phase_t     pr_phase;
  logic [7:0] pr_id;
  logic [7:0] pr_len;
  int         pr_count;
  logic [7:0] pr_sum;
  logic [7:0] pr_store [BUFFER_BYTES];

  // Decoded messages still owed by the block, oldest first.
  result_t pending_msgs [$];

  // Payload under construction for the next frame.
  logic [7:0] body [BUFFER_BYTES];

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] store_word(input int unsigned at);
    return {pr_store[at+3], pr_store[at+2], pr_store[at+1], pr_store[at]};
  endfunction

  // Exact square of the magnitude; the most negative word squares to 2^62.
  function automatic logic [65:0] square_mm(input logic [31:0] v);
    logic [31:0] m;
    logic [65:0] w;
    m = v[31] ? (~v + 32'd1) : v;
    w = {34'd0, m};
    return w * w;
  endfunction

  task automatic decode_frame();
    result_t     r;
    logic [31:0] x, y, z, d;
    logic [65:0] total, lim, w;
    int unsigned base;
    r = '0;
    if (pr_sum != 8'd0) return;
    // First match wins when ids coincide.
    if (pr_id == cur_cfg.id_bpos) r.kind = KIND_BPOS;
    else if (pr_id == cur_cfg.id_bdist) r.kind = KIND_BDIST;
    else if (pr_id == cur_cfg.id_vpos) r.kind = KIND_VPOS;
    else return;
    if (r.kind == KIND_BDIST) begin
      d = store_word(1);
      if (d > cur_cfg.max_range) return;
      r.station_id = pr_store[0];
      r.range      = d;
    end else begin
      base  = (r.kind == KIND_BPOS) ? 1 : 0;
      x     = store_word(base);
      y     = store_word(base + 4);
      z     = store_word(base + 8);
      total = square_mm(x) + square_mm(y) + square_mm(z);
      w     = {34'd0, cur_cfg.max_range};
      lim   = w * w;
      if (total > lim) return;
      r.station_id = (r.kind == KIND_BPOS) ? pr_store[0] : 8'd0;
      r.pos_x      = x;
      r.pos_y      = y;
      r.pos_z      = 33'd0 - {z[31], z};
    end
    pending_msgs.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] c);
    case (pr_phase)
      PH_HEADER: begin
        if (c == cur_cfg.header) begin
          pr_phase = PH_ID;
          pr_count = 0;
        end
      end
      PH_ID: begin
        pr_id = c;
        if (c == cur_cfg.id_bpos || c == cur_cfg.id_bdist || c == cur_cfg.id_vpos)
          pr_phase = PH_LEN;
        else
          pr_phase = PH_HEADER;
      end
      PH_LEN: begin
        pr_len = c;
        if (c > cur_cfg.max_len) begin
          pr_phase = PH_HEADER;
        end else begin
          pr_sum   = pr_id ^ c;
          pr_phase = PH_DATA;
        end
      end
      default: begin
        if (pr_count < BUFFER_BYTES) pr_store[pr_count] = c;
        pr_count++;
        pr_sum ^= c;
        // Length zero never matches the count, so such a frame runs to a full store.
        if (pr_count == pr_len || pr_count >= BUFFER_BYTES) begin
          decode_frame();
          pr_phase = PH_HEADER;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One byte request; push stays high into the next call so back-to-back bytes flow.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  // Leaves cfg_we high; the caller drops it after the last write of a batch.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      REG_HEADER:   cur_cfg.header    = d[7:0];
      REG_ID_BPOS:  cur_cfg.id_bpos   = d[7:0];
      REG_ID_BDIST: cur_cfg.id_bdist  = d[7:0];
      REG_ID_VPOS:  cur_cfg.id_vpos   = d[7:0];
      REG_MAX_LEN:  cur_cfg.max_len   = d[7:0];
      REG_MAX_RNG:  cur_cfg.max_range = d;
      default: ;
    endcase
  endtask

  // 8-bit value with random junk above it, which the block must drop.
  function automatic logic [31:0] wide8(input logic [7:0] v);
    logic [31:0] w;
    w      = $urandom();
    w[7:0] = v;
    return w;
  endfunction

  task automatic set_regs(input logic [7:0] hdr, input logic [7:0] bpos,
                          input logic [7:0] bdist, input logic [7:0] vpos,
                          input logic [7:0] max_len, input logic [31:0] max_rng);
    write_reg(REG_HEADER, wide8(hdr));
    write_reg(REG_ID_BPOS, wide8(bpos));
    write_reg(REG_ID_BDIST, wide8(bdist));
    write_reg(REG_ID_VPOS, wide8(vpos));
    write_reg(REG_MAX_LEN, wide8(max_len));
    write_reg(REG_MAX_RNG, max_rng);
    cfg_we <= 1'b0;
  endtask

  // Feed non-header bytes until the parser is back in header wait.
  task automatic to_header();
    logic [7:0] b;
    while (pr_phase != PH_HEADER) begin
      b = $urandom();
      if (b == cur_cfg.header) b = ~b;
      send_byte(b);
    end
  endtask

  // Bring the block to idle: no frame open, all results out, pipeline empty.
  task automatic settle();
    to_header();
    in_push <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] id_for(input kind_t k);
    case (k)
      KIND_BPOS:  return cur_cfg.id_bpos;
      KIND_BDIST: return cur_cfg.id_bdist;
      default:    return cur_cfg.id_vpos;
    endcase
  endfunction

  function automatic logic [7:0] natural_len(input kind_t k);
    case (k)
      KIND_BPOS:  return LEN_BPOS;
      KIND_BDIST: return LEN_BDIST;
      default:    return LEN_VPOS;
    endcase
  endfunction

  function automatic kind_t pick_kind();
    case ($urandom_range(0, 2))
      0:       return KIND_BPOS;
      1:       return KIND_BDIST;
      default: return KIND_VPOS;
    endcase
  endfunction

  function automatic logic [7:0] pick_len(input kind_t k);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return (natural_len(k) <= cur_cfg.max_len) ? natural_len(k) : LEN_FILL;
    if (sel < 85) return 8'($urandom_range(0, cur_cfg.max_len));
    return 8'($urandom());
  endfunction

  // Within half the limit per axis the sum of squares stays inside the limit.
  function automatic logic [31:0] pick_coord();
    int sel;
    logic [31:0] m;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 32'd0;
    if (sel < 75) begin
      m = $urandom_range(0, cur_cfg.max_range >> 1);
      return $urandom_range(0, 1) ? (~m + 32'd1) : m;
    end
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_distance();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return cur_cfg.max_range;
    if (sel < 75) return $urandom_range(0, cur_cfg.max_range);
    return $urandom();
  endfunction

  task automatic put_word(input int at, input logic [31:0] v);
    for (int k = 0; k < 4; k++) body[at+k] = v[8*k +: 8];
  endtask

  task automatic fill_body(input kind_t k);
    for (int i = 0; i < BUFFER_BYTES; i++) body[i] = $urandom();
    case (k)
      KIND_BPOS: begin
        put_word(1, pick_coord());
        put_word(5, pick_coord());
        put_word(9, pick_coord());
      end
      KIND_BDIST: put_word(1, pick_distance());
      default: begin
        put_word(0, pick_coord());
        put_word(4, pick_coord());
        put_word(8, pick_coord());
      end
    endcase
  endtask

  // Byte 0 carries the checksum fix: beacon id for beacon kinds, x LSB otherwise.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit good_sum);
    int n;
    logic [7:0] s;
    n = (len == LEN_FILL || len > BUFFER_BYTES) ? BUFFER_BYTES : len;
    s = id ^ len;
    for (int i = 1; i < n; i++) s ^= body[i];
    body[0] = good_sum ? s : (s ^ 8'h5A);
    send_byte(cur_cfg.header);
    send_byte(id);
    send_byte(len);
    for (int i = 0; i < n; i++) send_byte(body[i]);
  endtask

  task automatic random_burst();
    int sel, n;
    kind_t k;
    logic [7:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // line noise, with the header byte now and then
      n = $urandom_range(1, 6);
      repeat (n) send_byte(($urandom_range(0, 3) == 0) ? cur_cfg.header : 8'($urandom()));
    end else if (sel < 15) begin
      // broken frame: any id, any length, cut short or overrun
      send_byte(cur_cfg.header);
      send_byte($urandom_range(0, 1) ? id_for(pick_kind()) : 8'($urandom()));
      send_byte(8'($urandom()));
      n = $urandom_range(0, 20);
      repeat (n) send_byte(8'($urandom()));
    end else begin
      if ($urandom_range(0, 9) != 0) to_header();
      k   = pick_kind();
      len = pick_len(k);
      fill_body(k);
      send_frame(id_for(k), len, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic run_traffic();
    int first_byte;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < SECTION_BYTES)
      random_burst();
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    // Length zero first: fills every store entry before any short frame reads one.
    fill_body(KIND_BPOS);
    send_frame(cur_cfg.id_bpos, LEN_FILL, 1'b1);
    fill_body(KIND_BDIST);
    put_word(1, cur_cfg.max_range);
    send_frame(cur_cfg.id_bdist, LEN_BDIST, 1'b1);
    fill_body(KIND_BDIST);
    put_word(1, cur_cfg.max_range + 32'd1);
    send_frame(cur_cfg.id_bdist, LEN_BDIST, 1'b1);
    fill_body(KIND_VPOS);
    send_frame(cur_cfg.id_vpos, LEN_VPOS, 1'b1);
    // short payloads decode stale bytes from the frames above
    fill_body(KIND_BDIST);
    send_frame(cur_cfg.id_bdist, 8'd1, 1'b1);
    fill_body(KIND_VPOS);
    send_frame(cur_cfg.id_vpos, 8'd3, 1'b1);
  endtask

  task automatic test_frame_errors();
    fill_body(KIND_BDIST);
    put_word(1, 32'd10);
    send_frame(cur_cfg.id_bdist, LEN_BDIST, 1'b0);
    fill_body(KIND_BPOS);
    put_word(1, cur_cfg.max_range + 32'd1);
    put_word(5, 32'd0);
    put_word(9, 32'd0);
    send_frame(cur_cfg.id_bpos, LEN_BPOS, 1'b1);
    // unknown id, then a length over the limit; trailing bytes land as noise
    fill_body(KIND_BDIST);
    send_frame(8'hEE, LEN_BDIST, 1'b1);
    to_header();
    fill_body(KIND_BDIST);
    send_frame(cur_cfg.id_bdist, cur_cfg.max_len + 8'd1, 1'b1);
    to_header();
  endtask

  task automatic test_register_extremes();
    settle();
    set_regs(8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 32'hFFFF_FFFF);
    fill_body(KIND_BPOS);
    put_word(1, 32'h8000_0000);
    put_word(5, 32'h8000_0000);
    put_word(9, 32'h8000_0000);
    send_frame(cur_cfg.id_bpos, LEN_BPOS, 1'b1);
    fill_body(KIND_VPOS);
    put_word(0, 32'h7FFF_FFFF);
    put_word(4, 32'h7FFF_FFFF);
    put_word(8, 32'h7FFF_FFFF);
    send_frame(cur_cfg.id_vpos, LEN_VPOS, 1'b1);
    fill_body(KIND_BDIST);
    put_word(1, 32'hFFFF_FFFF);
    send_frame(cur_cfg.id_bdist, LEN_BDIST, 1'b1);
    // length above the store size: frame closes when the store is full
    fill_body(KIND_BDIST);
    send_frame(cur_cfg.id_bdist, 8'd200, 1'b1);
    settle();
    // unmapped indexes must leave every register alone
    write_reg(REG_UNMAPPED_LO, 32'h0000_0000);
    write_reg(REG_UNMAPPED_HI, 32'h0102_0304);
    cfg_we <= 1'b0;
    fill_body(KIND_BDIST);
    send_frame(cur_cfg.id_bdist, LEN_BDIST, 1'b1);
  endtask

  task automatic test_equal_ids();
    settle();
    set_regs(RST_HEADER, 8'h42, 8'h42, 8'h42, 8'd0, 32'd0);
    for (int i = 0; i < BUFFER_BYTES; i++) body[i] = 8'd0;
    send_frame(8'h42, LEN_FILL, 1'b1);
    fill_body(KIND_BDIST);
    send_frame(8'h42, LEN_BDIST, 1'b1);
    settle();
    set_regs(RST_HEADER, 8'h10, 8'h42, 8'h42, RST_MAX_LEN, RST_MAX_RNG);
    fill_body(KIND_BDIST);
    send_frame(8'h42, LEN_BDIST, 1'b1);
  endtask

  task automatic test_defaults_traffic();
    settle();
    set_regs(RST_HEADER, RST_ID_BPOS, RST_ID_BDIST, RST_ID_VPOS, RST_MAX_LEN, RST_MAX_RNG);
    run_traffic();
  endtask

  task automatic test_wide_traffic();
    settle();
    set_regs(8'hFF, 8'h00, 8'hFE, 8'h80, 8'hFF, 32'hFFFF_FFFF);
    run_traffic();
  endtask

  task automatic test_tight_traffic();
    settle();
    // vehicle id shadowed by beacon position; short lengths force fill-mode frames
    set_regs(8'h00, 8'h7F, 8'h80, 8'h7F, 8'd5, 32'd1000);
    run_traffic();
  endtask

  task automatic test_random_config_traffic();
    settle();
    set_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
             8'($urandom_range(0, 255)),
             $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 300000));
    run_traffic();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop at random, check each popped request against the oldest
  // predicted message. Outputs are sampled at the edge before the block updates.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_msgs.size() == 0) begin
        $error("result with none expected: msg_kind %0d", out_msg_kind);
        error_count++;
      end else begin
        want = pending_msgs.pop_front();
        check_field("msg_kind", want.kind, out_msg_kind);
        check_field("station_id", want.station_id, out_station_id);
        check_field("pos_x_mm", {1'b0, want.pos_x}, {1'b0, out_pos_x_mm});
        check_field("pos_y_mm", {1'b0, want.pos_y}, {1'b0, out_pos_y_mm});
        check_field("pos_z_mm", want.pos_z, out_pos_z_mm);
        check_field("range_mm", {1'b0, want.range}, {1'b0, out_range_mm});
      end
    end
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: any request moving on either side restarts the count.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_beacon_frame_parser_core: errors");
      $finish;
    end
  end

  initial begin
    cur_cfg.header    = RST_HEADER;
    cur_cfg.id_bpos   = RST_ID_BPOS;
    cur_cfg.id_bdist  = RST_ID_BDIST;
    cur_cfg.id_vpos   = RST_ID_VPOS;
    cur_cfg.max_len   = RST_MAX_LEN;
    cur_cfg.max_range = RST_MAX_RNG;
    pr_phase = PH_HEADER;
    pr_id    = 8'd0;
    pr_len   = 8'd0;
    pr_count = 0;
    pr_sum   = 8'd0;
    for (int i = 0; i < BUFFER_BYTES; i++) pr_store[i] = 8'd0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 15;
    recv_idle_pct = 74;
    test_reset_values();
    test_frame_errors();
    test_register_extremes();
    test_equal_ids();
    test_defaults_traffic();
    test_wide_traffic();

    // sender sparse, receiver eager
    send_idle_pct = 74;
    recv_idle_pct = 15;
    test_tight_traffic();
    test_random_config_traffic();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_config_traffic();
    test_wide_traffic();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_msgs.size() == 0) begin
      $display("tb_beacon_frame_parser_core: clean");
    end else begin
      $display("tb_beacon_frame_parser_core: errors");
    end
    $finish;
  end

endmodule
